@@ hdl/dashed_line_rasterizer_core_defines.svh @@
// ----------------------------------------------------------------------------
// Dashed line rasterizer: shared assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled while rst_ni
// is low.
// ----------------------------------------------------------------------------
`ifndef DASHED_LINE_RASTERIZER_CORE_DEFINES_SVH
`define DASHED_LINE_RASTERIZER_CORE_DEFINES_SVH

// Checks that a condition holds at every clock edge.
`define DLR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define DLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dlr_pkg.sv @@
// ----------------------------------------------------------------------------
// Dashed line rasterizer package
// Item types, field widths, codes and frame defaults shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

  // Field widths.
  localparam int CoordW = 9;
  localparam int IndexW = 17;
  localparam int ErrW   = 12;
  localparam int DashW  = 8;
  localparam int LevelW = 8;

  // Default frame size.
  localparam int FrameWidth  = 400;
  localparam int FrameHeight = 240;

  // Level written for a white pixel.
  localparam logic [LevelW-1:0] LevelOn = 8'd255;

  // Item modes.
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeStep = 1'b1;

  // Input item.
  typedef struct packed {
    logic              mode;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic [DashW-1:0]  dash_period;
    logic              pixel_on;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic [IndexW-1:0] pixel_index;
    logic [LevelW-1:0] level;
    logic              write;
    logic              done_res;
  } out_item_t;

endpackage

`default_nettype wire

@@ hdl/dashed_line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// Dashed line rasterizer core
// Bresenham line stepper with a dash period, one point per item.
// ----------------------------------------------------------------------------
// Usage:
//   An item on the input channel (in_valid_i / in_ready_o / in_item_i) either
//   loads a new line (mode load: endpoints, dash period, pixel value) and
//   visits its start point, or advances the loaded line by one step.
//   Every accepted item gives exactly one result on the output channel
//   (out_valid_o / out_ready_i / out_item_o): the visited point, its frame
//   index, the level and the write and done flags.
//   The result is registered: it is valid in the cycle after acceptance.
//   Throughput is one item per cycle while the receiver takes each result;
//   the line state update and the frame index multiply sit between the line
//   state registers and the result register.
//   When the receiver stalls, the result register holds its item and
//   in_ready_o drops until the result is taken; no item is lost.
//   Reset clears the line state (no line loaded, dash length one) and empties
//   the result register. A step with no line loaded reports done and no write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dashed_line_rasterizer_core_defines.svh"

module dashed_line_rasterizer_core #(
  parameter int FRAME_WIDTH  = dlr_pkg::FrameWidth,
  parameter int FRAME_HEIGHT = dlr_pkg::FrameHeight
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire dlr_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output dlr_pkg::out_item_t      out_item_o
);

  localparam int CW = dlr_pkg::CoordW;
  localparam int EW = dlr_pkg::ErrW;
  localparam int DW = dlr_pkg::DashW;
  localparam int XW = EW + 2;
  localparam int DimW = CW + 1;
  localparam int ProdW = CW + DimW;
  localparam logic [DimW-1:0] FrameWLim = DimW'(FRAME_WIDTH);
  localparam logic [DimW-1:0] FrameHLim = DimW'(FRAME_HEIGHT);
  localparam logic [ProdW:0]  FrameArea = (ProdW + 1)'(FRAME_WIDTH * FRAME_HEIGHT);

  // Line state.
  logic [CW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CW-1:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic [CW-1:0] span_x_q, span_x_d, span_y_q, span_y_d;
  logic          step_x_neg_q, step_x_neg_d, step_y_neg_q, step_y_neg_d;
  logic [EW-1:0] err_q, err_d;
  logic [DW-1:0] dash_count_q, dash_count_d, dash_len_q, dash_len_d;
  logic          held_value_q, held_value_d, line_active_q, line_active_d;

  // Result register.
  logic               out_valid_q;
  dlr_pkg::out_item_t out_item_q, out_item_d;

  logic in_fire;
  logic is_load;
  logic at_end, in_frame, draw;
  logic [DW-1:0] dash_base;
  logic [DW:0]   dash_inc;
  logic signed [XW-1:0] err_ext, e2, dx_s, dy_s, err_sum;
  logic move_x, move_y;
  logic [ProdW-1:0] index_full;

  // Accept whenever the result register is free or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_load    = (in_item_i.mode == dlr_pkg::ModeLoad);

  // Bresenham step decisions on the held error term.
  assign err_ext = XW'($signed(err_q));
  assign e2      = err_ext <<< 1;
  assign dx_s    = $signed({{(XW-CW){1'b0}}, span_x_q});
  assign dy_s    = -$signed({{(XW-CW){1'b0}}, span_y_q});
  assign move_x  = (e2 >= dy_s);
  assign move_y  = (e2 <= dx_s);
  assign err_sum = err_ext + (move_x ? dy_s : '0) + (move_y ? dx_s : '0);

  // Next line state for the visited point.
  always_comb begin
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    goal_x_d     = goal_x_q;
    goal_y_d     = goal_y_q;
    span_x_d     = span_x_q;
    span_y_d     = span_y_q;
    step_x_neg_d = step_x_neg_q;
    step_y_neg_d = step_y_neg_q;
    err_d        = err_q;
    dash_len_d   = dash_len_q;
    held_value_d = held_value_q;
    dash_base    = dash_count_q;
    if (is_load) begin
      cur_x_d      = in_item_i.start_x;
      cur_y_d      = in_item_i.start_y;
      goal_x_d     = in_item_i.end_x;
      goal_y_d     = in_item_i.end_y;
      step_x_neg_d = !(in_item_i.start_x < in_item_i.end_x);
      step_y_neg_d = !(in_item_i.start_y < in_item_i.end_y);
      span_x_d     = step_x_neg_d ? in_item_i.start_x - in_item_i.end_x
                                  : in_item_i.end_x - in_item_i.start_x;
      span_y_d     = step_y_neg_d ? in_item_i.start_y - in_item_i.end_y
                                  : in_item_i.end_y - in_item_i.start_y;
      err_d        = {{(EW-CW){1'b0}}, span_x_d} - {{(EW-CW){1'b0}}, span_y_d};
      dash_len_d   = (in_item_i.dash_period == '0) ? DW'(1) : in_item_i.dash_period;
      held_value_d = in_item_i.pixel_on;
      dash_base    = '0;
    end else if (line_active_q) begin
      if (move_x) begin
        cur_x_d = step_x_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
      end
      if (move_y) begin
        cur_y_d = step_y_neg_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
      end
      err_d = err_sum[EW-1:0];
    end
  end

  // Visit: dash counter, endpoint test and frame test on the new point.
  assign at_end   = (cur_x_d == goal_x_d) && (cur_y_d == goal_y_d);
  assign in_frame = ({1'b0, cur_x_d} < FrameWLim) && ({1'b0, cur_y_d} < FrameHLim);
  assign dash_inc = {1'b0, dash_base} + (DW + 1)'(1);
  assign index_full = ProdW'(cur_y_d) * ProdW'(FrameWLim) + ProdW'(cur_x_d);

  always_comb begin
    dash_count_d  = dash_count_q;
    line_active_d = line_active_q;
    draw          = 1'b0;
    if (is_load || line_active_q) begin
      draw          = (dash_base == '0) && in_frame;
      dash_count_d  = (dash_inc == {1'b0, dash_len_d}) ? '0 : dash_inc[DW-1:0];
      line_active_d = !at_end;
    end
  end

  // Result item for the visited point.
  always_comb begin
    out_item_d.point_x     = cur_x_d;
    out_item_d.point_y     = cur_y_d;
    out_item_d.pixel_index = in_frame ? index_full[dlr_pkg::IndexW-1:0] : '0;
    out_item_d.level       = held_value_d ? dlr_pkg::LevelOn : '0;
    out_item_d.write       = draw;
    out_item_d.done_res    = (is_load || line_active_q) ? at_end : 1'b1;
  end

  // Line state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      goal_x_q      <= '0;
      goal_y_q      <= '0;
      span_x_q      <= '0;
      span_y_q      <= '0;
      step_x_neg_q  <= 1'b0;
      step_y_neg_q  <= 1'b0;
      err_q         <= '0;
      dash_count_q  <= '0;
      dash_len_q    <= DW'(1);
      held_value_q  <= 1'b0;
      line_active_q <= 1'b0;
    end else if (in_fire) begin
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      goal_x_q      <= goal_x_d;
      goal_y_q      <= goal_y_d;
      span_x_q      <= span_x_d;
      span_y_q      <= span_y_d;
      step_x_neg_q  <= step_x_neg_d;
      step_y_neg_q  <= step_y_neg_d;
      err_q         <= err_d;
      dash_count_q  <= dash_count_d;
      dash_len_q    <= dash_len_d;
      held_value_q  <= held_value_d;
      line_active_q <= line_active_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Assertions.
  `DLR_ASSERT(a_dash_in_range, dash_count_q < dash_len_q,
    "dash counter reached the dash length")
  `DLR_ASSERT(a_idle_at_goal, line_active_q || (cur_x_q == goal_x_q && cur_y_q == goal_y_q),
    "no line active but current point is not the goal")
  `DLR_ASSERT_NEXT(a_step_after_done,
    in_fire && !line_active_q && in_item_i.mode == dlr_pkg::ModeStep,
    out_item_o.done_res && !out_item_o.write,
    "step with no active line must report done without a write")
  `DLR_ASSERT(a_write_in_frame,
    !(out_valid_o && out_item_o.write) || ({{(ProdW + 1 - dlr_pkg::IndexW){1'b0}},
      out_item_o.pixel_index} < FrameArea),
    "written pixel index lies outside the frame")

endmodule

`default_nettype wire
